// ===== sv/mst_pkg.sv =====
`timescale 1ns / 1ps

package mst_pkg;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int KIND_W   = 2;
  localparam int HANDLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int STEP_W   = 10;

  // Tick step after reset, in milliseconds
  localparam logic [STEP_W-1:0] STEP_RESET = 10'd10;

  // Most expiry words reported for one tick
  localparam int MAX_RESULTS = 16;
  localparam int REP_W       = $clog2(MAX_RESULTS + 1);

  // Command codes
  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_TICK  = 2'd0;
  localparam mode_t MODE_START = 2'd1;
  localparam mode_t MODE_STOP  = 2'd2;
  localparam mode_t MODE_NONE  = 2'd3;

  // Result codes
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_OK      = 2'd0;
  localparam kind_t KIND_FULL    = 2'd1;
  localparam kind_t KIND_EXPIRED = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

// ===== sv/mst_ram.sv =====
`timescale 1ns / 1ps

module mst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/multi_slot_software_timer_top.sv =====
// Table of SLOTS software timers keyed by a 16-bit handle.
// Input channel: a command word is taken at a clock edge with start high and
// busy low. in_mode selects tick, start timer or stop timer; mode 3 is taken
// and ignored. Start re-arms the slot holding the handle or claims the lowest
// free slot; stop frees the slot holding the handle.
// Result channel: every result word is shown for exactly one cycle with
// out_valid high; the receiver cannot stall it. Start and stop give one word
// (accepted, or start dropped because the table is full). A tick gives one
// expiry word per expiring slot (at most MAX_RESULTS) in slot order, none if
// nothing expires, and out_last marks the final word of the command.
// Timing: each command walks the whole table, one slot per cycle, through the
// registered read port of the slot memories, so busy stays high through the
// walk and the done state, and no new command is taken until busy falls.
// The final result word is shown in the first cycle with busy low; earlier
// expiry words of a tick appear while busy is high.
// Configuration: cfg_we writes the tick step (ms); the user must write it
// only while the block is idle; the block does not enforce it. Reset (rst_n
// low, synchronous) frees all slots, sets the tick step to 10 ms and needs
// no clearing pass; slot memories keep old data until a start writes them.
`timescale 1ns / 1ps

module multi_slot_software_timer_top #(
  parameter int SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [mst_pkg::MODE_W-1:0]     in_mode,
  input  logic [mst_pkg::HANDLE_W-1:0]   in_timer_handle,
  input  logic [mst_pkg::TIME_W-1:0]     in_timeout_ms,
  input  logic                           in_periodic,
  input  logic                           cfg_we,
  input  logic [mst_pkg::STEP_W-1:0]     cfg_wdata,
  output logic                           out_valid,
  output logic [mst_pkg::KIND_W-1:0]     out_result_kind,
  output logic [mst_pkg::HANDLE_W-1:0]   out_result_handle,
  output logic                           out_last
);

  import mst_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CFG_W  = HANDLE_W + TIME_W + 1;

  // Control registers
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               p_vld_r, p_vld_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SLOTS-1:0]   used_r, used_nxt;
  logic [SLOTS-1:0]   active_r, active_nxt;
  logic               hit_r, hit_nxt;
  logic               free_r, free_nxt;
  logic               held_vld_r, held_vld_nxt;
  logic [REP_W-1:0]   rep_r, rep_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload registers
  logic [SLOT_W-1:0]   p_idx_r, p_idx_nxt;
  mode_t               mode_r, mode_nxt;
  logic [HANDLE_W-1:0] hdl_r, hdl_nxt;
  logic [TIME_W-1:0]   tmo_r, tmo_nxt;
  logic                per_r, per_nxt;
  logic [SLOT_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [SLOT_W-1:0]   free_idx_r, free_idx_nxt;
  logic [HANDLE_W-1:0] held_hdl_r, held_hdl_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                out_last_r, out_last_nxt;

  // Memory ports
  logic              a_we, b_we;
  logic [SLOT_W-1:0] waddr, raddr;
  logic [CFG_W-1:0]  a_wdata, a_rdata;
  logic [TIME_W-1:0] b_wdata, b_rdata;

  // Read-side slot fields and tick arithmetic
  logic [HANDLE_W-1:0] rd_hdl;
  logic [TIME_W-1:0]   rd_tmo;
  logic                rd_per;
  logic [TIME_W:0]     sum;
  logic [TIME_W-1:0]   sat;
  logic                expired;
  logic                accept;
  logic                walk_end;
  logic [SLOT_W-1:0]   tgt_idx;

  // Slot memories: {handle, timeout, periodic} and elapsed count
  mst_ram #(.WIDTH(CFG_W), .DEPTH(SLOTS)) u_cfg_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (a_wdata),
    .raddr (raddr),
    .rdata (a_rdata)
  );

  mst_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_cnt_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (b_wdata),
    .raddr (raddr),
    .rdata (b_rdata)
  );

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign walk_end = (cnt_r == CNT_W'(SLOTS));
  assign raddr    = cnt_r[SLOT_W-1:0];

  assign rd_hdl = a_rdata[CFG_W-1 -: HANDLE_W];
  assign rd_tmo = a_rdata[TIME_W:1];
  assign rd_per = a_rdata[0];

  // Saturating add of the step, then compare against the timeout
  assign sum     = {1'b0, b_rdata} + {{(TIME_W + 1 - STEP_W){1'b0}}, step_r};
  assign sat     = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  assign expired = (sat >= rd_tmo);

  assign tgt_idx = hit_r ? hit_idx_r : free_idx_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_mode != MODE_NONE) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Walk the table, update slots and form result words
  always_comb begin
    cnt_nxt        = cnt_r;
    p_vld_nxt      = 1'b0;
    p_idx_nxt      = cnt_r[SLOT_W-1:0];
    step_nxt       = step_r;
    used_nxt       = used_r;
    active_nxt     = active_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    held_vld_nxt   = held_vld_r;
    held_hdl_nxt   = held_hdl_r;
    rep_nxt        = rep_r;
    mode_nxt       = mode_r;
    hdl_nxt        = hdl_r;
    tmo_nxt        = tmo_r;
    per_nxt        = per_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = KIND_OK;
    out_handle_nxt = hdl_r;
    out_last_nxt   = 1'b1;
    a_we           = 1'b0;
    b_we           = 1'b0;
    waddr          = p_idx_r;
    a_wdata        = {hdl_r, tmo_r, per_r};
    b_wdata        = sat;

    if (cfg_we) begin
      step_nxt = cfg_wdata;
    end

    // Latch the command word and clear the search state
    if (accept) begin
      mode_nxt     = in_mode;
      hdl_nxt      = in_timer_handle;
      tmo_nxt      = in_timeout_ms;
      per_nxt      = in_periodic;
      cnt_nxt      = '0;
      hit_nxt      = 1'b0;
      free_nxt     = 1'b0;
      held_vld_nxt = 1'b0;
      rep_nxt      = '0;
    end

    // Issue one slot read per cycle
    if (state_r == ST_WALK && !walk_end) begin
      cnt_nxt   = cnt_r + CNT_W'(1);
      p_vld_nxt = 1'b1;
    end

    // Process the slot whose read data has arrived
    if (p_vld_r) begin
      case (mode_r) inside
        MODE_TICK: begin
          if (used_r[p_idx_r] && active_r[p_idx_r]) begin
            b_we = 1'b1;
            if (expired) begin
              if (rd_per) begin
                b_wdata = '0;
              end else begin
                active_nxt[p_idx_r] = 1'b0;
              end
              if (rep_r != REP_W'(MAX_RESULTS)) begin
                // Release the held word; the newest one waits for its last flag
                if (held_vld_r) begin
                  out_valid_nxt  = 1'b1;
                  out_kind_nxt   = KIND_EXPIRED;
                  out_handle_nxt = held_hdl_r;
                  out_last_nxt   = 1'b0;
                end
                held_vld_nxt = 1'b1;
                held_hdl_nxt = rd_hdl;
                rep_nxt      = rep_r + REP_W'(1);
              end
            end
          end
        end
        MODE_START, MODE_STOP: begin
          if (used_r[p_idx_r] && rd_hdl == hdl_r && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = p_idx_r;
          end
          if (!used_r[p_idx_r] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = p_idx_r;
          end
        end
        default: begin
        end
      endcase
    end

    // Finish the command
    if (state_r == ST_DONE) begin
      case (mode_r)
        MODE_TICK: begin
          if (held_vld_r) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_EXPIRED;
            out_handle_nxt = held_hdl_r;
          end
        end
        MODE_START: begin
          out_valid_nxt = 1'b1;
          if (hit_r || free_r) begin
            a_we                = 1'b1;
            b_we                = 1'b1;
            waddr               = tgt_idx;
            b_wdata             = '0;
            used_nxt[tgt_idx]   = 1'b1;
            active_nxt[tgt_idx] = 1'b1;
          end else begin
            out_kind_nxt = KIND_FULL;
          end
        end
        MODE_STOP: begin
          out_valid_nxt = 1'b1;
          if (hit_r) begin
            used_nxt[hit_idx_r]   = 1'b0;
            active_nxt[hit_idx_r] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      p_vld_r     <= 1'b0;
      step_r      <= STEP_RESET;
      used_r      <= '0;
      active_r    <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      held_vld_r  <= 1'b0;
      rep_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      p_vld_r     <= p_vld_nxt;
      step_r      <= step_nxt;
      used_r      <= used_nxt;
      active_r    <= active_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      held_vld_r  <= held_vld_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    p_idx_r      <= p_idx_nxt;
    mode_r       <= mode_nxt;
    hdl_r        <= hdl_nxt;
    tmo_r        <= tmo_nxt;
    per_r        <= per_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    held_hdl_r   <= held_hdl_nxt;
    out_kind_r   <= out_kind_nxt;
    out_handle_r <= out_handle_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_result_handle = out_handle_r;
  assign out_last          = out_last_r;

  // A slot is never active unless it is allocated
  a_active_used: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r & ~used_r) == '0)
    else $error("active slot not allocated");

  // Start and stop results always close their command
  a_cmd_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != KIND_EXPIRED |-> out_last_r)
    else $error("command result without last flag");

  // A real command keeps the block busy on the next cycle
  a_busy_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode != MODE_NONE |=> busy)
    else $error("command taken without entering the walk");

  // Reported expiries never exceed the per-tick limit
  a_rep_limit: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r <= REP_W'(MAX_RESULTS))
    else $error("too many expiry words counted");

endmodule

// ===== tb/multi_slot_software_timer_top_test.sv =====
`timescale 1ns / 1ps

module multi_slot_software_timer_top_test;
  import mst_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int POOL_SIZE   = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 30;

  typedef struct packed {
    kind_t               kind;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } timer_word_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  mode_t               in_mode;
  logic [HANDLE_W-1:0] in_timer_handle;
  logic [TIME_W-1:0]   in_timeout_ms;
  logic                in_periodic;
  logic                cfg_we;
  logic [STEP_W-1:0]   cfg_wdata;
  logic                out_valid;
  kind_t               out_result_kind;
  logic [HANDLE_W-1:0] out_result_handle;
  logic                out_last;

  // Shadow copy of the timer table and the tick step
  logic                slot_used     [NUM_SLOTS];
  logic                slot_active   [NUM_SLOTS];
  logic [HANDLE_W-1:0] slot_handle   [NUM_SLOTS];
  logic [TIME_W-1:0]   slot_elapsed  [NUM_SLOTS];
  logic [TIME_W-1:0]   slot_timeout  [NUM_SLOTS];
  logic                slot_periodic [NUM_SLOTS];
  logic [STEP_W-1:0]   step_ms;

  // Result words still to come from the block, oldest first
  timer_word_t timer_words_due[$];
  timer_word_t oldest_word;

  logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];

  int          mismatch_count;
  int          words_checked;
  int          tick_count;
  int          start_count;
  int          stop_count;
  int          expiry_count;
  int          full_count;
  int          step_settings;
  int          no_idle_left;
  int unsigned cycle_count;

  multi_slot_software_timer_top #(
    .SLOTS(NUM_SLOTS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_timer_handle  (in_timer_handle),
    .in_timeout_ms    (in_timeout_ms),
    .in_periodic      (in_periodic),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_result_kind  (out_result_kind),
    .out_result_handle(out_result_handle),
    .out_last         (out_last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run timed out with %0d result words outstanding", timer_words_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("MISMATCH at %0t ns: %s", $realtime, what);
  endtask

  task automatic push_word(input kind_t kind, input logic [HANDLE_W-1:0] h, input logic last);
    timer_word_t w;
    w.kind   = kind;
    w.handle = h;
    w.last   = last;
    timer_words_due.push_back(w);
  endtask

  function automatic int find_timer(input logic [HANDLE_W-1:0] h);
    int slot;
    slot = -1;
    for (int i = NUM_SLOTS - 1; i >= 0; i--)
      if (slot_used[i] && slot_handle[i] == h) slot = i;
    return slot;
  endfunction

  // Apply one command to the shadow table and queue the words it causes
  task automatic advance_timer_table(input mode_t m, input logic [HANDLE_W-1:0] h,
                                     input logic [TIME_W-1:0] to, input logic per);
    int                  slot;
    int                  fired;
    logic [TIME_W:0]     sum;
    logic [HANDLE_W-1:0] fired_handle [MAX_RESULTS];
    fired = 0;
    slot  = -1;
    case (m)
      MODE_TICK: begin
        tick_count++;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_used[i] && slot_active[i]) begin
            // Saturate the count instead of wrapping
            sum = {1'b0, slot_elapsed[i]} + step_ms;
            slot_elapsed[i] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
            if (slot_elapsed[i] >= slot_timeout[i]) begin
              if (fired < MAX_RESULTS) begin
                fired_handle[fired] = slot_handle[i];
                fired++;
              end
              if (slot_periodic[i]) slot_elapsed[i] = '0;
              else slot_active[i] = 1'b0;
            end
          end
        end
        for (int k = 0; k < fired; k++)
          push_word(KIND_EXPIRED, fired_handle[k], k == fired - 1);
        expiry_count += fired;
      end
      MODE_START: begin
        start_count++;
        slot = find_timer(h);
        if (slot < 0)
          for (int i = NUM_SLOTS - 1; i >= 0; i--)
            if (!slot_used[i]) slot = i;
        if (slot < 0) begin
          full_count++;
          push_word(KIND_FULL, h, 1'b1);
        end else begin
          slot_used[slot]     = 1'b1;
          slot_active[slot]   = 1'b1;
          slot_handle[slot]   = h;
          slot_timeout[slot]  = to;
          slot_periodic[slot] = per;
          slot_elapsed[slot]  = '0;
          push_word(KIND_OK, h, 1'b1);
        end
      end
      MODE_STOP: begin
        stop_count++;
        slot = find_timer(h);
        if (slot >= 0) begin
          slot_used[slot]   = 1'b0;
          slot_active[slot] = 1'b0;
        end
        push_word(KIND_OK, h, 1'b1);
      end
      default: ;
    endcase
  endtask

  // Present one command word, hold it until taken, then idle for a random gap
  task automatic send_command(input mode_t m, input logic [HANDLE_W-1:0] h,
                              input logic [TIME_W-1:0] to, input logic per);
    int gap;
    @(negedge clk);
    start           <= 1'b1;
    in_mode         <= m;
    in_timer_handle <= h;
    in_timeout_ms   <= to;
    in_periodic     <= per;
    @(posedge clk);
    while (busy) @(posedge clk);
    advance_timer_table(m, h, to, per);
    if (no_idle_left > 0) begin
      no_idle_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 15) == 0) no_idle_left = $urandom_range(5, 20);
      gap = $urandom_range(0, 9);
    end
    // Count the gap in cycles where the block is ready again
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      while (gap > 0) begin
        @(posedge clk);
        if (!busy) gap--;
      end
    end
  endtask

  // Drop start and let the block finish everything it owes
  task automatic drain_table_work;
    @(negedge clk);
    start <= 1'b0;
    while (timer_words_due.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 5) @(posedge clk);
  endtask

  task automatic write_tick_step(input logic [STEP_W-1:0] value);
    drain_table_work();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    step_ms = value;
    step_settings++;
  endtask

  // Mostly well-formed traffic over a shared handle pool; mode 3 words are extra
  task automatic run_random_commands(input int count);
    int                  done;
    int                  pick;
    mode_t               m;
    logic [HANDLE_W-1:0] h;
    logic [TIME_W-1:0]   to;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      h    = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
      case ($urandom_range(0, 9))
        0:       to = '0;
        1:       to = {TIME_W{1'b1}};
        2:       to = $urandom;
        default: to = $urandom_range(0, 6 * step_ms + 5);
      endcase
      if (pick < 4) m = MODE_NONE;
      else if (pick < 46) m = MODE_TICK;
      else if (pick < 82) m = MODE_START;
      else begin
        m = MODE_STOP;
        if ($urandom_range(0, 9) == 0) h = HANDLE_W'($urandom_range(0, 65535));
      end
      send_command(m, h, to, 1'($urandom_range(0, 1)));
      if (m != MODE_NONE) done++;
    end
  endtask

  task automatic test_directed_cases;
    // One-shot with zero timeout, and the widest handle and timeout
    send_command(MODE_START, 16'h0000, '0, 1'b0);
    send_command(MODE_START, 16'hFFFF, {TIME_W{1'b1}}, 1'b1);
    send_command(MODE_TICK, HANDLE_W'($urandom), $urandom, 1'b0);
    // Re-arm a handle that is still allocated, then let it fire periodically
    send_command(MODE_START, 16'h0000, 32'd20, 1'b1);
    send_command(MODE_TICK, '0, '0, 1'b0);
    send_command(MODE_TICK, '1, '1, 1'b1);
    // Stop of an unknown handle, then of a held one
    send_command(MODE_STOP, 16'h1234, '0, 1'b0);
    send_command(MODE_STOP, 16'h0000, '0, 1'b0);
    send_command(MODE_NONE, HANDLE_W'($urandom), $urandom, 1'b1);
    // Fill the table, overflow it, and fire nearly every slot in one tick
    for (int i = 0; i < 15; i++)
      send_command(MODE_START, HANDLE_W'(16'h0100 + i), TIME_W'((i % 3) * 5), i[0]);
    send_command(MODE_START, 16'h7E57, 32'd1, 1'b0);
    send_command(MODE_TICK, '0, '0, 1'b0);
    send_command(MODE_STOP, 16'hFFFF, '0, 1'b0);
  endtask

  task automatic test_step_extremes;
    write_tick_step(10'd1);
    run_random_commands(70);
    write_tick_step(10'd1023);
    run_random_commands(70);
    write_tick_step(10'd0);
    run_random_commands(70);
    write_tick_step(10'd1000);
    run_random_commands(70);
  endtask

  task automatic test_random_steps;
    repeat (2) begin
      write_tick_step(STEP_W'($urandom_range(2, 999)));
      run_random_commands(60);
    end
  endtask

  // Compare each result word with the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      words_checked++;
      if (timer_words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d handle %h last %0b",
                                  out_result_kind, out_result_handle, out_last));
      end else begin
        oldest_word = timer_words_due.pop_front();
        if (out_result_kind !== oldest_word.kind)
          report_mismatch($sformatf("kind %0d, want %0d (handle %h)",
                                    out_result_kind, oldest_word.kind, oldest_word.handle));
        if (out_result_handle !== oldest_word.handle)
          report_mismatch($sformatf("handle %h, want %h",
                                    out_result_handle, oldest_word.handle));
        if (out_last !== oldest_word.last)
          report_mismatch($sformatf("last %0b, want %0b (handle %h)",
                                    out_last, oldest_word.last, oldest_word.handle));
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_mode         = MODE_TICK;
    in_timer_handle = '0;
    in_timeout_ms   = '0;
    in_periodic     = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    step_ms         = STEP_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_used[i]     = 1'b0;
      slot_active[i]   = 1'b0;
      slot_handle[i]   = '0;
      slot_elapsed[i]  = '0;
      slot_timeout[i]  = '0;
      slot_periodic[i] = 1'b0;
    end
    // Pool holds every handle the directed part leaves allocated
    for (int i = 0; i < 15; i++) handle_pool[i] = HANDLE_W'(16'h0100 + i);
    handle_pool[15] = 16'hFFFF;
    handle_pool[16] = 16'h0000;
    for (int i = 17; i < POOL_SIZE; i++) handle_pool[i] = HANDLE_W'($urandom_range(0, 65535));

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_step_extremes();
    test_random_steps();

    drain_table_work();
    if (timer_words_due.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", timer_words_due.size()));
    $display("Covered %0d ticks, %0d starts and %0d stops across %0d tick step settings",
             tick_count, start_count, stop_count, step_settings + 1);
    $display("Checked %0d result words: %0d expiries, %0d starts dropped on a full table",
             words_checked, expiry_count, full_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mst_pkg.sv
sv/mst_ram.sv
sv/multi_slot_software_timer_top.sv
tb/multi_slot_software_timer_top_test.sv
